[rtl/whdb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// whdb_pkg
// Shared types and constants for the Walsh-Hadamard delay-feedback butterfly.
// ----------------------------------------------------------------------------
package whdb_pkg;

	localparam int BLOCK_LEN = 1024;
	localparam int MAX_DELAY = 512;

	localparam int SAMPLE_W = 24;
	localparam int VALUE_W  = SAMPLE_W + 1;
	localparam int MODE_W   = 2;
	localparam int DLEN_W   = 10;
	localparam int DATA_W   = DLEN_W;
	localparam int ADDR_W   = $clog2(MAX_DELAY);
	localparam int SPAN_W   = $clog2(MAX_DELAY + 1);
	localparam int POS_W    = $clog2(BLOCK_LEN + MAX_DELAY);
	localparam int STEP_W   = $clog2(POS_W);

	typedef enum logic [0:0] {
		REG_MODE  = 1'b0,
		REG_DELAY = 1'b1
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SUM_DIFF  = 2'd0,
		MODE_DIFF_SUM  = 2'd1,
		MODE_SUM_RDIFF = 2'd2,
		MODE_RDIFF_SUM = 2'd3
	} mode_t;

	// what one word does to the delay store
	typedef enum logic [1:0] {
		KIND_FILL = 2'd0,
		KIND_PAIR = 2'd1,
		KIND_SEND = 2'd2,
		KIND_SKIP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RC_IDLE = 2'd0,
		RC_LOAD = 2'd1,
		RC_DIV  = 2'd2
	} rc_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		kind_t             kind;
		logic              last;
		logic              flush;
	} item_ctl_t;

endpackage : whdb_pkg
`default_nettype wire

[rtl/whdb_index.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// whdb_index
// Block position, store index and half-group tracking. A span write rebuilds
// the index and half bit from the position, bit-serially past the first span.
// ----------------------------------------------------------------------------
module whdb_index (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          span_wr,
	input  wire logic [whdb_pkg::DLEN_W-1:0]   span_data,
	output whdb_pkg::item_ctl_t                ctl,
	output logic                               busy
);

	whdb_pkg::rc_state_t state_q, state_nx;

	logic [whdb_pkg::SPAN_W-1:0] span_q;
	logic [whdb_pkg::SPAN_W-1:0] span_new;
	logic [whdb_pkg::POS_W-1:0]  p_q;
	logic [whdb_pkg::ADDR_W-1:0] idx_q;
	logic                        half_q;

	logic [whdb_pkg::POS_W-1:0]  num_q;
	logic [whdb_pkg::ADDR_W-1:0] rem_q;
	logic [whdb_pkg::STEP_W-1:0] cnt_q;

	logic [whdb_pkg::POS_W-1:0]  total;
	logic [whdb_pkg::POS_W-1:0]  p_inc;
	logic [whdb_pkg::SPAN_W-1:0] idx_inc;
	logic                        wrap;
	logic                        pre;
	logic                        active;

	logic [whdb_pkg::ADDR_W:0]   r_sh;
	logic                        r_ge;
	logic [whdb_pkg::ADDR_W:0]   r_nx;

	logic ld_direct, ld_div, div_step, div_done;

	always_comb begin
		if (span_data == '0)
			span_new = whdb_pkg::SPAN_W'(1);
		else if (32'(span_data) > whdb_pkg::MAX_DELAY)
			span_new = whdb_pkg::SPAN_W'(whdb_pkg::MAX_DELAY);
		else
			span_new = whdb_pkg::SPAN_W'(span_data);
	end

	assign total   = whdb_pkg::POS_W'(whdb_pkg::BLOCK_LEN) + whdb_pkg::POS_W'(span_q);
	assign p_inc   = p_q + 1'b1;
	assign idx_inc = whdb_pkg::SPAN_W'(idx_q) + 1'b1;
	assign wrap    = (idx_inc == span_q);
	assign pre     = (p_q < whdb_pkg::POS_W'(span_q));
	assign active  = (p_q < total);

	always_comb begin
		ctl.addr  = idx_q;
		ctl.last  = (p_q == total - 1'b1);
		ctl.flush = (32'(p_q) >= whdb_pkg::BLOCK_LEN);
		if (pre)
			ctl.kind = whdb_pkg::KIND_FILL;
		else if (!active)
			ctl.kind = whdb_pkg::KIND_SKIP;
		else if (half_q)
			ctl.kind = whdb_pkg::KIND_SEND;
		else
			ctl.kind = whdb_pkg::KIND_PAIR;
	end

	// restoring division step: remainder and quotient lsb only
	assign r_sh = {rem_q, num_q[whdb_pkg::POS_W-1]};
	assign r_ge = (r_sh >= (whdb_pkg::ADDR_W+1)'(span_q));
	assign r_nx = r_ge ? (r_sh - (whdb_pkg::ADDR_W+1)'(span_q)) : r_sh;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			whdb_pkg::RC_IDLE: begin
				if (span_wr)
					state_nx = whdb_pkg::RC_LOAD;
			end
			whdb_pkg::RC_LOAD: begin
				state_nx = pre ? whdb_pkg::RC_IDLE : whdb_pkg::RC_DIV;
			end
			whdb_pkg::RC_DIV: begin
				if (cnt_q == whdb_pkg::STEP_W'(whdb_pkg::POS_W - 1))
					state_nx = whdb_pkg::RC_IDLE;
			end
			default: state_nx = whdb_pkg::RC_IDLE;
		endcase
		if (span_wr)
			state_nx = whdb_pkg::RC_LOAD;
	end

	always_comb begin
		busy      = 1'b1;
		ld_direct = 1'b0;
		ld_div    = 1'b0;
		div_step  = 1'b0;
		div_done  = 1'b0;
		case (state_q)
			whdb_pkg::RC_IDLE: busy = 1'b0;
			whdb_pkg::RC_LOAD: begin
				ld_direct = pre;
				ld_div    = !pre;
			end
			whdb_pkg::RC_DIV: begin
				div_step = 1'b1;
				div_done = (cnt_q == whdb_pkg::STEP_W'(whdb_pkg::POS_W - 1));
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= whdb_pkg::RC_IDLE;
			span_q  <= whdb_pkg::SPAN_W'(1);
			p_q     <= '0;
			idx_q   <= '0;
			half_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (span_wr)
				span_q <= span_new;
			if (ld_direct) begin
				idx_q  <= p_q[whdb_pkg::ADDR_W-1:0];
				half_q <= 1'b0;
			end
			if (ld_div)
				cnt_q <= '0;
			else if (div_step)
				cnt_q <= cnt_q + 1'b1;
			if (div_done) begin
				idx_q  <= r_nx[whdb_pkg::ADDR_W-1:0];
				half_q <= r_ge;
			end
			if (accept) begin
				if (p_inc >= total) begin
					p_q    <= '0;
					idx_q  <= '0;
					half_q <= 1'b0;
				end else begin
					p_q   <= p_inc;
					idx_q <= wrap ? '0 : idx_inc[whdb_pkg::ADDR_W-1:0];
					if (pre)
						half_q <= 1'b0;
					else if (wrap)
						half_q <= !half_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_div) begin
			num_q <= p_q - whdb_pkg::POS_W'(span_q);
			rem_q <= '0;
		end else if (div_step) begin
			num_q <= {num_q[whdb_pkg::POS_W-2:0], 1'b0};
			rem_q <= r_nx[whdb_pkg::ADDR_W-1:0];
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !accept)
		else $error("word accepted during index rebuild");

	a_idx_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (whdb_pkg::SPAN_W'(idx_q) < span_q))
		else $error("store index beyond span");

	a_half_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && half_q) |-> (p_q >= (whdb_pkg::POS_W'(span_q) << 1)))
		else $error("second half flagged before two spans");

endmodule : whdb_index
`default_nettype wire

[rtl/whdb_bfly.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// whdb_bfly
// Delay store, read-modify-write butterfly stage with write forwarding, and
// the result register.
// ----------------------------------------------------------------------------
module whdb_bfly (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire whdb_pkg::item_ctl_t                 ctl,
	input  wire logic signed [whdb_pkg::SAMPLE_W-1:0] sample,
	input  wire whdb_pkg::mode_t                     mode,
	output logic                                     s1_free,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic signed [whdb_pkg::VALUE_W-1:0]      value,
	output logic                                     last
);

	logic signed [whdb_pkg::VALUE_W-1:0] mem [whdb_pkg::MAX_DELAY];
	logic signed [whdb_pkg::VALUE_W-1:0] rd_q;

	logic                                s1_valid;
	logic [whdb_pkg::ADDR_W-1:0]         addr_s1;
	whdb_pkg::kind_t                     kind_s1;
	logic                                last_s1;
	logic signed [whdb_pkg::VALUE_W-1:0] b_s1;

	logic                                wr_valid_q;
	logic [whdb_pkg::ADDR_W-1:0]         wr_addr_q;
	logic signed [whdb_pkg::VALUE_W-1:0] wr_data_q;

	logic signed [whdb_pkg::VALUE_W-1:0] a;
	logic signed [whdb_pkg::VALUE_W-1:0] sum, amb, bma;
	logic signed [whdb_pkg::VALUE_W-1:0] res, wdata;
	logic                                has_res;
	logic                                s1_adv;
	logic                                wr_en;

	assign a = (wr_valid_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_q;

	assign sum = a + b_s1;
	assign amb = a - b_s1;
	assign bma = b_s1 - a;

	always_comb begin
		res   = a;
		wdata = b_s1;
		case (kind_s1)
			whdb_pkg::KIND_PAIR: begin
				case (mode)
					whdb_pkg::MODE_SUM_DIFF: begin
						res   = sum;
						wdata = amb;
					end
					whdb_pkg::MODE_DIFF_SUM: begin
						res   = amb;
						wdata = sum;
					end
					whdb_pkg::MODE_SUM_RDIFF: begin
						res   = sum;
						wdata = bma;
					end
					default: begin
						res   = bma;
						wdata = sum;
					end
				endcase
			end
			whdb_pkg::KIND_SEND: begin
				res   = a;
				wdata = b_s1;
			end
			default: begin
				res   = a;
				wdata = b_s1;
			end
		endcase
	end

	assign has_res = (kind_s1 == whdb_pkg::KIND_PAIR) || (kind_s1 == whdb_pkg::KIND_SEND);
	assign s1_adv  = s1_valid && (!has_res || !result_valid || !result_stall);
	assign s1_free = !s1_valid || s1_adv;
	assign wr_en   = s1_adv && (kind_s1 != whdb_pkg::KIND_SKIP);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_s1] <= wdata;
		if (accept)
			rd_q <= mem[ctl.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid     <= 1'b0;
			wr_valid_q   <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (accept)
				s1_valid <= 1'b1;
			else if (s1_adv)
				s1_valid <= 1'b0;
			if (wr_en)
				wr_valid_q <= 1'b1;
			if (s1_adv && has_res)
				result_valid <= 1'b1;
			else if (!result_stall)
				result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= ctl.addr;
			kind_s1 <= ctl.kind;
			last_s1 <= ctl.last;
			b_s1    <= ctl.flush ? '0 : whdb_pkg::VALUE_W'(sample);
		end
		if (wr_en) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= wdata;
		end
		if (s1_adv && has_res) begin
			value <= res;
			last  <= last_s1;
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_adv) |=> (s1_valid && $stable(addr_s1) && $stable(b_s1)))
		else $error("butterfly stage lost a held word");

	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(s1_valid))
		else $error("result without a word in the butterfly stage");

	a_skip_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && kind_s1 == whdb_pkg::KIND_SKIP) |-> (!wr_en && !(s1_adv && has_res)))
		else $error("skipped word touched store or output");

endmodule : whdb_bfly
`default_nettype wire

[rtl/walsh_hadamard_delay_butterfly.sv]
`default_nettype none
// A result is formed in the butterfly stage and then held in the result register.
// Throughput: one word per cycle while sample_stall is low; the delay store is read
// per word and written back unless skipped. A delay_len write holds sample_stall
// while the index is rebuilt from the position, bit-serially past the first span.
// Reset clears position, mode (0) and span (1); the delay store is not cleared.
// ----------------------------------------------------------------------------
// walsh_hadamard_delay_butterfly
// Streamed radix-2 Walsh-Hadamard stage, single-path delay-feedback form.
// ----------------------------------------------------------------------------
module walsh_hadamard_delay_butterfly (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic [0:0]                           wr_index,
	input  wire logic [whdb_pkg::DATA_W-1:0]          wr_data,
	input  wire logic                                 sample_valid,
	output logic                                      sample_stall,
	input  wire logic signed [whdb_pkg::SAMPLE_W-1:0] sample,
	output logic                                      result_valid,
	input  wire logic                                 result_stall,
	output logic signed [whdb_pkg::VALUE_W-1:0]       value,
	output logic                                      last
);

	whdb_pkg::mode_t     mode_q;
	whdb_pkg::item_ctl_t ctl;
	logic                busy;
	logic                s1_free;
	logic                accept;
	logic                span_wr;

	assign sample_stall = busy || !s1_free;
	assign accept       = sample_valid && !sample_stall;
	assign span_wr      = wr_en && (wr_index == whdb_pkg::REG_DELAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= whdb_pkg::MODE_SUM_DIFF;
		end else if (wr_en && (wr_index == whdb_pkg::REG_MODE)) begin
			mode_q <= whdb_pkg::mode_t'(wr_data[whdb_pkg::MODE_W-1:0]);
		end
	end

	whdb_index u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.span_wr   (span_wr),
		.span_data (wr_data[whdb_pkg::DLEN_W-1:0]),
		.ctl       (ctl),
		.busy      (busy)
	);

	whdb_bfly u_bfly (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.ctl          (ctl),
		.sample       (sample),
		.mode         (mode_q),
		.s1_free      (s1_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.last         (last)
	);

endmodule : walsh_hadamard_delay_butterfly
`default_nettype wire

[verif/tb_walsh_hadamard_delay_butterfly.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_walsh_hadamard_delay_butterfly
// Streams words through the butterfly stage under random sender bursts and
// receiver stalls. It predicts each result word from its own copy of the
// delay store and block position, and compares value and last in order. It
// covers all four modes, a span beyond the limit, span zero, a span that does
// not divide the block, and span changes in the middle of a block.
// ----------------------------------------------------------------------------
module tb_walsh_hadamard_delay_butterfly;

	localparam int WATCHDOG_LIMIT = 2000;

	class wht_stage_scoreboard;
		typedef struct {
			logic signed [whdb_pkg::VALUE_W-1:0] value;
			logic                                last;
		} bfly_out_t;

		logic signed [whdb_pkg::VALUE_W-1:0] delay_line [whdb_pkg::MAX_DELAY];
		int unsigned                         pos;
		whdb_pkg::mode_t                     mode;
		logic [whdb_pkg::DLEN_W-1:0]         dlen;
		bfly_out_t                           outs [$];
		int                                  errors;

		function new();
			foreach (delay_line[i]) delay_line[i] = '0;
			pos    = 0;
			mode   = whdb_pkg::MODE_SUM_DIFF;
			dlen   = whdb_pkg::DLEN_W'(1);
			errors = 0;
		endfunction

		function int unsigned span();
			if (dlen == 0) return 1;
			if (dlen > whdb_pkg::MAX_DELAY) return whdb_pkg::MAX_DELAY;
			return dlen;
		endfunction

		function int pending();
			return outs.size();
		endfunction

		function void set_reg(whdb_pkg::reg_idx_t idx, logic [whdb_pkg::DATA_W-1:0] data);
			case (idx)
				whdb_pkg::REG_MODE: begin
					mode = whdb_pkg::mode_t'(data[whdb_pkg::MODE_W-1:0]);
				end
				whdb_pkg::REG_DELAY: begin
					dlen = data[whdb_pkg::DLEN_W-1:0];
				end
				default: ;
			endcase
		endfunction

		function void note_sample(logic signed [whdb_pkg::SAMPLE_W-1:0] s);
			int unsigned                         d;
			int unsigned                         total;
			int unsigned                         q;
			int unsigned                         idx;
			logic signed [whdb_pkg::VALUE_W-1:0] a;
			logic signed [whdb_pkg::VALUE_W-1:0] b;
			logic signed [whdb_pkg::VALUE_W-1:0] sum;
			logic signed [whdb_pkg::VALUE_W-1:0] amb;
			logic signed [whdb_pkg::VALUE_W-1:0] bma;
			logic signed [whdb_pkg::VALUE_W-1:0] res;
			logic signed [whdb_pkg::VALUE_W-1:0] keep;
			bfly_out_t                           o;
			d     = span();
			total = whdb_pkg::BLOCK_LEN + d;
			b     = whdb_pkg::VALUE_W'(s);
			if (pos >= whdb_pkg::BLOCK_LEN) b = '0;
			if (pos < d) begin
				delay_line[pos] = b;
			end else if (pos < total) begin
				q   = pos - d;
				idx = q % d;
				if (((q / d) & 1) == 0) begin
					a   = delay_line[idx];
					sum = a + b;
					amb = a - b;
					bma = b - a;
					case (mode)
						whdb_pkg::MODE_SUM_DIFF: begin
							res = sum; keep = amb;
						end
						whdb_pkg::MODE_DIFF_SUM: begin
							res = amb; keep = sum;
						end
						whdb_pkg::MODE_SUM_RDIFF: begin
							res = sum; keep = bma;
						end
						default: begin
							res = bma; keep = sum;
						end
					endcase
					delay_line[idx] = keep;
				end else begin
					res             = delay_line[idx];
					delay_line[idx] = b;
				end
				if (q < whdb_pkg::BLOCK_LEN) begin
					o.value = res;
					o.last  = (q == whdb_pkg::BLOCK_LEN - 1);
					outs.push_back(o);
				end
			end
			pos++;
			if (pos >= total) pos = 0;
		endfunction

		function void check_result(logic signed [whdb_pkg::VALUE_W-1:0] value, logic last);
			bfly_out_t e;
			if (outs.size() == 0) begin
				$error("unexpected result word: value %0d, last %0b", value, last);
				errors++;
				return;
			end
			e = outs.pop_front();
			if (value !== e.value) begin
				$error("value mismatch: expected %0d, actual %0d", e.value, value);
				errors++;
			end
			if (last !== e.last) begin
				$error("last mismatch: expected %0b, actual %0b", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                                 clk          = 1'b0;
	logic                                 arst_n       = 1'b0;
	logic                                 wr_en        = 1'b0;
	logic [0:0]                           wr_index     = whdb_pkg::REG_MODE;
	logic [whdb_pkg::DATA_W-1:0]          wr_data      = '0;
	logic                                 sample_valid = 1'b0;
	logic                                 sample_stall;
	logic signed [whdb_pkg::SAMPLE_W-1:0] sample       = '0;
	logic                                 result_valid;
	logic                                 result_stall = 1'b0;
	logic signed [whdb_pkg::VALUE_W-1:0]  value;
	logic                                 last;

	wht_stage_scoreboard sb = new();

	int burst_left  = 0;
	int stall_left  = 0;
	int stall_style = 0;
	int idle_cycles = 0;

	walsh_hadamard_delay_butterfly i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern, restyled when stall_left reaches zero
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_left  <= $urandom_range(50, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= ((stall_left % 7) < 3);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(value, last);
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic signed [whdb_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $urandom_range(0, 1) ? 24'sh000000 : 24'shFFFFFF;
			default: return whdb_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// sender bursts: mostly back to back, sometimes with short gaps
	task automatic send_word(input logic signed [whdb_pkg::SAMPLE_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 64);
			gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_valid <= 1'b1;
		sample       <= s;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		sb.note_sample(s);
	endtask

	task automatic run_words(input int n);
		repeat (n) send_word(rand_sample());
	endtask

	// stop sending and let every expected word come out
	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input whdb_pkg::mode_t m, input logic [whdb_pkg::DLEN_W-1:0] d);
		drain();
		wr_en    <= 1'b1;
		wr_index <= whdb_pkg::REG_MODE;
		wr_data  <= whdb_pkg::DATA_W'(m);
		@(posedge clk);
		sb.set_reg(whdb_pkg::REG_MODE, whdb_pkg::DATA_W'(m));
		wr_index <= whdb_pkg::REG_DELAY;
		wr_data  <= d;
		@(posedge clk);
		sb.set_reg(whdb_pkg::REG_DELAY, d);
		wr_en <= 1'b0;
	endtask

	initial begin
		logic signed [whdb_pkg::SAMPLE_W-1:0] corner_words [20];
		corner_words = '{
			24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
			24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
			24'sh000000, 24'shFFFFFF, 24'shFFFFFF, 24'sh000000,
			24'sh000001, 24'shFFFFFF, 24'sh555555, 24'shAAAAAA,
			24'shAAAAAA, 24'sh555555, 24'sh123456, 24'shEDCBA9
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// span beyond the limit acts as 512; fills every store entry
		configure(whdb_pkg::MODE_DIFF_SUM, 10'd1023);
		run_words(514);

		// span zero acts as one; corner words pair up in order
		configure(whdb_pkg::MODE_SUM_DIFF, 10'd0);
		foreach (corner_words[i]) send_word(corner_words[i]);

		// mid-block span changes, one not dividing the block
		configure(whdb_pkg::MODE_SUM_RDIFF, 10'd3);
		run_words(16);
		configure(whdb_pkg::MODE_RDIFF_SUM, 10'd16);
		run_words(16);

		drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule : tb_walsh_hadamard_delay_butterfly
`default_nettype wire

[sim.f]
rtl/whdb_pkg.sv
rtl/whdb_index.sv
rtl/whdb_bfly.sv
rtl/walsh_hadamard_delay_butterfly.sv
verif/tb_walsh_hadamard_delay_butterfly.sv
